### hdl/kci_pkg.sv
`default_nettype none

package kci_pkg;

  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_START_TIME  = 3'd1,
    REG_END_TIME    = 3'd2,
    REG_START_VALUE = 3'd3,
    REG_END_VALUE   = 3'd4,
    REG_CTRL1_VALUE = 3'd5,
    REG_CTRL2_VALUE = 3'd6
  } cfg_reg_t;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam int         MODE_CURVE_BIT = 1;

  // per-item control flags carried alongside the data
  typedef struct packed {
    logic byp;       // result is a keyframe value, not interpolated
    logic pick_end;  // keyframe value is end_value (else start_value)
  } ctl_t;

endpackage

`default_nettype wire

### hdl/keyframe_channel_interpolator.sv
// Throughput: one item per cycle while the skid entry is empty; the FRAC_BITS-stage divider
// forming t and the three two-stage lerp levels of the Bezier set the depth, and every stage
// advances together, stalling only while the skid entry is occupied.
// Output register plus skid entry: input keeps flowing while one result waits.
// Reset (rst_n low, synchronous): pipeline and output emptied, mode = linear,
// all time and value registers = 0.
`default_nettype none

module keyframe_channel_interpolator #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,   // [31:0] query_time
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [31:0]                   out_tdata,  // [31:0] channel_value
  input  wire logic                          cfg_we,
  input  wire logic [kci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  import kci_pkg::*;

  localparam int NS = FRAC_BITS + 9;  // valid stages
  localparam int NC = FRAC_BITS + 7;  // control stages, from the decision stage on

  // configuration
  logic [1:0] mode_r;
  val_t       start_time_r, end_time_r;
  val_t       start_value_r, end_value_r, ctrl1_value_r, ctrl2_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_LINEAR;
      start_time_r  <= '0;
      end_time_r    <= '0;
      start_value_r <= '0;
      end_value_r   <= '0;
      ctrl1_value_r <= '0;
      ctrl2_value_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:        mode_r        <= cfg_wdata[1:0];
        REG_START_TIME:  start_time_r  <= cfg_wdata;
        REG_END_TIME:    end_time_r    <= cfg_wdata;
        REG_START_VALUE: start_value_r <= cfg_wdata;
        REG_END_VALUE:   end_value_r   <= cfg_wdata;
        REG_CTRL1_VALUE: ctrl1_value_r <= cfg_wdata;
        REG_CTRL2_VALUE: ctrl2_value_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // span for the divider; config is stable long before an item gets there
  logic [VAL_W-1:0] span_cfg_r;
  always_ff @(posedge clk) begin
    span_cfg_r <= end_time_r - start_time_r;
  end

  // pipeline control: whole pipe moves unless the skid entry is occupied
  logic          en;
  logic [NS-1:0] v_r;
  logic          out_valid_r, skid_valid_r;
  val_t          out_data_r, skid_data_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end

  // stage A: capture query
  val_t q_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= in_tdata;
    end
  end

  // stage B: time offset and span, exact 33 bits
  logic signed [VAL_W:0] d_r, span_r;
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= $signed({q_r[VAL_W-1], q_r}) - $signed({start_time_r[VAL_W-1], start_time_r});
      span_r <= $signed({end_time_r[VAL_W-1], end_time_r})
                - $signed({start_time_r[VAL_W-1], start_time_r});
    end
  end

  // stage C: classify the query
  logic [VAL_W+1:0] d_minus_span;
  logic             span_le0, d_ge0, d_le0, d_ge_span, hold;
  ctl_t             ctl_nxt;
  ctl_t             ctl_r [NC];
  logic [VAL_W-1:0] num_r;

  assign d_minus_span = {d_r[VAL_W], d_r} - {span_r[VAL_W], span_r};
  assign span_le0     = span_r[VAL_W] || (span_r == '0);
  assign d_ge0        = !d_r[VAL_W];
  assign d_le0        = d_r[VAL_W] || (d_r == '0);
  assign d_ge_span    = !d_minus_span[VAL_W+1];
  assign hold         = (mode_r == MODE_HOLD);

  always_comb begin
    ctl_nxt.byp      = hold || span_le0 || d_ge_span || d_le0;
    ctl_nxt.pick_end = !hold && (span_le0 ? d_ge0 : d_ge_span);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_nxt;
      num_r    <= d_r[VAL_W-1:0];
      for (int k = 1; k < NC; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // fraction t
  logic [FRAC_BITS-1:0] t_div;

  kci_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .en  (en),
    .num (num_r),
    .den (span_cfg_r),
    .quo (t_div)
  );

  // de Casteljau levels; lane 0 of level 1 doubles as the linear lerp
  logic [FRAC_BITS-1:0] t_pipe_r [4];
  val_t                 lin_r    [4];
  val_t                 y1 [3];
  val_t                 y2 [2];
  val_t                 y3;
  val_t                 lane0_b;

  assign lane0_b = mode_r[MODE_CURVE_BIT] ? ctrl1_value_r : end_value_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_pipe_r[0] <= t_div;
      lin_r[0]    <= y1[0];
      for (int k = 1; k < 4; k++) begin
        t_pipe_r[k] <= t_pipe_r[k-1];
        lin_r[k]    <= lin_r[k-1];
      end
    end
  end

  kci_lerp #(.FRAC_BITS(FRAC_BITS)) u_l1a (
    .clk(clk), .en(en), .a(start_value_r), .b(lane0_b), .t(t_div), .y(y1[0]));
  kci_lerp #(.FRAC_BITS(FRAC_BITS)) u_l1b (
    .clk(clk), .en(en), .a(ctrl1_value_r), .b(ctrl2_value_r), .t(t_div), .y(y1[1]));
  kci_lerp #(.FRAC_BITS(FRAC_BITS)) u_l1c (
    .clk(clk), .en(en), .a(ctrl2_value_r), .b(end_value_r), .t(t_div), .y(y1[2]));

  kci_lerp #(.FRAC_BITS(FRAC_BITS)) u_l2a (
    .clk(clk), .en(en), .a(y1[0]), .b(y1[1]), .t(t_pipe_r[1]), .y(y2[0]));
  kci_lerp #(.FRAC_BITS(FRAC_BITS)) u_l2b (
    .clk(clk), .en(en), .a(y1[1]), .b(y1[2]), .t(t_pipe_r[1]), .y(y2[1]));

  kci_lerp #(.FRAC_BITS(FRAC_BITS)) u_l3 (
    .clk(clk), .en(en), .a(y2[0]), .b(y2[1]), .t(t_pipe_r[3]), .y(y3));

  // result select
  ctl_t ctl_last;
  val_t res;
  logic push;

  assign ctl_last = ctl_r[NC-1];
  assign push     = en && v_r[NS-1];

  always_comb begin
    if (ctl_last.byp) begin
      res = ctl_last.pick_end ? end_value_r : start_value_r;
    end else if (mode_r[MODE_CURVE_BIT]) begin
      res = y3;
    end else begin
      res = lin_r[3];
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (push) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (push) begin
        skid_data_r <= res;
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (push) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### hdl/kci_div.sv
`default_nettype none

// Pipelined restoring divider: quo = floor(num * 2^FRAC_BITS / den), for num < den.
// One quotient bit per stage, FRAC_BITS stages.
module kci_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [kci_pkg::VAL_W-1:0] num,
  input  wire logic [kci_pkg::VAL_W-1:0] den,
  output logic      [FRAC_BITS-1:0]      quo
);
  import kci_pkg::*;

  logic [VAL_W-1:0]     rem_r [FRAC_BITS-1];
  logic [FRAC_BITS-1:0] quo_r [FRAC_BITS];

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_stage
    logic [VAL_W-1:0]     rem_in;
    logic [FRAC_BITS-1:0] quo_in;
    logic [VAL_W:0]       sh;
    logic [VAL_W+1:0]     dif;
    logic                 ge;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign sh  = {rem_in, 1'b0};
    assign dif = {1'b0, sh} - {2'b00, den};
    assign ge  = !dif[VAL_W+1];

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= {quo_in[FRAC_BITS-2:0], ge};
      end
    end

    if (j < FRAC_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? dif[VAL_W-1:0] : sh[VAL_W-1:0];
        end
      end
    end
  end

  assign quo = quo_r[FRAC_BITS-1];

endmodule

`default_nettype wire

### hdl/kci_lerp.sv
`default_nettype none

// y = sat(a + round((b - a) * t / 2^FRAC_BITS)), ties toward +inf. Two stages.
module kci_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire kci_pkg::val_t        a,
  input  wire kci_pkg::val_t        b,
  input  wire logic [FRAC_BITS-1:0] t,
  output kci_pkg::val_t             y
);
  import kci_pkg::*;

  localparam int PW    = VAL_W + FRAC_BITS + 2;
  localparam int SUM_W = VAL_W + 4;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

  logic signed [VAL_W:0]     diff;
  logic signed [FRAC_BITS:0] tt;
  logic signed [PW-1:0]      prod_r;
  val_t                      a_r;
  logic signed [PW:0]        rnd;
  logic signed [VAL_W+2:0]   sh;
  logic signed [SUM_W-1:0]   sum;
  val_t                      y_nxt;
  val_t                      y_r;

  assign diff = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
  assign tt   = $signed({1'b0, t});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(diff) * PW'(tt);
      a_r    <= a;
    end
  end

  assign rnd = $signed({prod_r[PW-1], prod_r}) + HALF;
  assign sh  = rnd[PW:FRAC_BITS];  // floor by arithmetic shift
  assign sum = SUM_W'(a_r) + SUM_W'(sh);

  always_comb begin
    if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1) begin
      y_nxt = sum[VAL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      y_nxt = VAL_MIN;
    end else begin
      y_nxt = VAL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import kci_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int DRAIN_CYCLES = FRAC_BITS + 9 + 16;
  localparam int RANDOM_ITEMS = 1200;
  localparam int RUN_LIMIT    = 500_000;

  localparam logic [1:0] MODE_CURVE    = 2'd1 << MODE_CURVE_BIT;
  localparam logic [1:0] MODE_CURVE_HI = MODE_CURVE | MODE_LINEAR;

  typedef struct {
    logic [1:0] mode;
    val_t       st;
    val_t       et;
    val_t       sv;
    val_t       ev;
    val_t       c1;
    val_t       c2;
  } kf_cfg_t;

  typedef struct {
    logic        load;
    kf_cfg_t     cfg;
    logic [31:0] query;
    logic        known;
    logic [31:0] value;
  } probe_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [31:0]          cfg_wdata = '0;

  kf_cfg_t     kf_model;
  logic [31:0] expected_values[$];
  probe_row_t  probe_rows[$];
  logic [31:0] want_value;
  int          mismatches = 0;
  int          burst_left = 0;
  int          ready_left = 0;
  logic        ready_level = 1'b0;

  keyframe_channel_interpolator #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [31:0] query_time
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [31:0] channel_value
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic longint clamp_to_word(longint v);
    if (v > longint'(VAL_MAX)) return longint'(VAL_MAX);
    if (v < longint'(VAL_MIN)) return longint'(VAL_MIN);
    return v;
  endfunction

  // a + round((b - a) * t), ties toward plus infinity
  function automatic longint blend(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t + (longint'(1) <<< (FRAC_BITS - 1));
    return clamp_to_word(a + (p >>> FRAC_BITS));
  endfunction

  function automatic logic [31:0] predict_channel(logic [31:0] q);
    longint qs, d, span, t, a, b, c, e, f, res;
    qs   = $signed(q);
    d    = qs - longint'(kf_model.st);
    span = longint'(kf_model.et) - longint'(kf_model.st);
    if (kf_model.mode == MODE_HOLD) begin
      res = kf_model.sv;
    end else if (span <= 0) begin
      res = (d >= 0) ? longint'(kf_model.ev) : longint'(kf_model.sv);
    end else if (d >= span) begin
      res = kf_model.ev;
    end else if (d <= 0) begin
      res = kf_model.sv;
    end else begin
      t = (d <<< FRAC_BITS) / span;
      if (kf_model.mode[MODE_CURVE_BIT]) begin
        a   = blend(kf_model.sv, kf_model.c1, t);
        b   = blend(kf_model.c1, kf_model.c2, t);
        c   = blend(kf_model.c2, kf_model.ev, t);
        e   = blend(a, b, t);
        f   = blend(b, c, t);
        res = blend(e, f, t);
      end else begin
        res = blend(kf_model.sv, kf_model.ev, t);
      end
    end
    res = clamp_to_word(res);
    return res[31:0];
  endfunction

  function automatic kf_cfg_t kf(logic [1:0] mode, val_t st, val_t et, val_t sv, val_t ev,
                                 val_t c1, val_t c2);
    kf_cfg_t c;
    c.mode = mode;
    c.st   = st;
    c.et   = et;
    c.sv   = sv;
    c.ev   = ev;
    c.c1   = c1;
    c.c2   = c2;
    return c;
  endfunction

  function automatic val_t pick_value();
    int r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3, 4:    return val_t'(int'($urandom_range(0, 32'h7_ffff)) - 32'h4_0000);
      default: return val_t'(r);
    endcase
  endfunction

  function automatic kf_cfg_t pick_keyframes();
    kf_cfg_t c;
    longint  st, span;
    int      r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:          c.mode = MODE_HOLD;
      1, 2, 3, 4: c.mode = MODE_LINEAR;
      9:          c.mode = MODE_CURVE_HI;
      default:    c.mode = MODE_CURVE;
    endcase
    case ($urandom_range(0, 7))
      0:       st = VAL_MIN;
      1:       st = VAL_MAX;
      2, 3:    st = r;
      default: st = longint'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
    endcase
    case ($urandom_range(0, 9))
      0:       span = 0;
      1:       span = -longint'($urandom_range(1, 32'h10_0000));
      2, 3:    span = $urandom_range(1, 256);
      7, 8:    span = $urandom_range(1, 32'h7fff_ffff);
      9:       span = longint'($urandom);
      default: span = $urandom_range(1, 32'h10_0000);
    endcase
    c.st = val_t'(st);
    c.et = val_t'(clamp_to_word(st + span));
    c.sv = pick_value();
    c.ev = pick_value();
    c.c1 = pick_value();
    c.c2 = pick_value();
    return c;
  endfunction

  // mostly inside the keyframe window, plus its edges and the full range
  function automatic logic [31:0] pick_query(kf_cfg_t c);
    longint          lo, hi, margin, q;
    longint unsigned width, r;
    int              k, r32;
    lo = c.st;
    hi = c.et;
    if (hi < lo) begin
      q  = lo;
      lo = hi;
      hi = q;
    end
    margin = (hi - lo) / 8 + 2;
    k      = $urandom_range(0, 2);
    r32    = $urandom;
    case ($urandom_range(0, 9))
      6:       q = longint'(c.st) + k - 1;
      7:       q = longint'(c.et) + k - 1;
      8:       q = r32;
      9:       q = $urandom_range(0, 1) ? longint'(VAL_MAX) : longint'(VAL_MIN);
      default: begin
        width = hi - lo + 2 * margin + 1;
        r     = {$urandom, $urandom};
        q     = lo - margin + longint'(r % width);
      end
    endcase
    q = clamp_to_word(q);
    return q[31:0];
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_MODE:        kf_model.mode = data[1:0];
      REG_START_TIME:  kf_model.st = data;
      REG_END_TIME:    kf_model.et = data;
      REG_START_VALUE: kf_model.sv = data;
      REG_END_VALUE:   kf_model.ev = data;
      REG_CTRL1_VALUE: kf_model.c1 = data;
      REG_CTRL2_VALUE: kf_model.c2 = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_keyframes(kf_cfg_t c);
    write_reg(REG_MODE, {30'd0, c.mode});
    write_reg(REG_START_TIME, c.st);
    write_reg(REG_END_TIME, c.et);
    write_reg(REG_START_VALUE, c.sv);
    write_reg(REG_END_VALUE, c.ev);
    write_reg(REG_CTRL1_VALUE, c.c1);
    write_reg(REG_CTRL2_VALUE, c.c2);
    cfg_we = 1'b0;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_query(logic [31:0] q, logic known, logic [31:0] value);
    int gap;
    in_tvalid = 1'b1;
    in_tdata  = q;
    do @(posedge clk); while (!in_tready);
    expected_values.push_back(known ? value : predict_channel(q));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      gap       = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 12);
    end
  endtask

  // block is idle once every transfer has come back and the pipe has flushed
  task automatic settle();
    in_tvalid = 1'b0;
    while (expected_values.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_probe(logic load, kf_cfg_t c, logic [31:0] q, logic known,
                           logic [31:0] value);
    probe_row_t row;
    row.load  = load;
    row.cfg   = c;
    row.query = q;
    row.known = known;
    row.value = value;
    probe_rows.push_back(row);
  endtask

  always @(negedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          ready_level = 1'b0;
          ready_left  = $urandom_range(1, 24);
        end
        1: begin
          ready_level = 1'b1;
          ready_left  = $urandom_range(50, 300);
        end
        default: begin
          ready_level = $urandom_range(0, 1);
          ready_left  = $urandom_range(1, 6);
        end
      endcase
    end
    ready_left--;
    out_tready = ready_level;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        $display("%0t: channel_value transfer with none pending: expected none, actual %h",
                 $time, out_tdata);
      end else begin
        want_value = expected_values.pop_front();
        if (out_tdata !== want_value) begin
          mismatches++;
          $display("%0t: channel_value mismatch: expected %h, actual %h",
                   $time, want_value, out_tdata);
        end
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("keyframe_channel_interpolator regression: fail");
    $finish;
  end

  initial begin
    kf_cfg_t c;
    int      sent, phase, n;
    kf_model = kf(MODE_LINEAR, '0, '0, '0, '0, '0, '0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset state: zero span at time zero
    c = kf_model;
    add_probe(1'b0, c, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_probe(1'b0, c, VAL_MIN, 1'b1, 32'h0000_0000);
    c = kf(MODE_LINEAR, 32'h0, 32'h0004_0000, 32'h0001_0000, 32'h0005_0000, 32'h0, 32'h0);
    add_probe(1'b1, c, 32'h0002_0000, 1'b1, 32'h0003_0000);
    add_probe(1'b0, c, 32'h0004_0000, 1'b1, 32'h0005_0000);
    add_probe(1'b0, c, 32'h0000_0000, 1'b1, 32'h0001_0000);
    add_probe(1'b0, c, VAL_MAX, 1'b1, 32'h0005_0000);
    add_probe(1'b0, c, VAL_MIN, 1'b1, 32'h0001_0000);
    add_probe(1'b0, c, 32'h0003_ffff, 1'b0, '0);
    add_probe(1'b0, c, 32'h0000_0001, 1'b0, '0);
    // hold mode ignores the end keyframe
    c = kf(MODE_HOLD, 32'h0, 32'h0004_0000, 32'h0001_2345, 32'h0006_789a, 32'h0, 32'h0);
    add_probe(1'b1, c, VAL_MAX, 1'b1, 32'h0001_2345);
    add_probe(1'b0, c, 32'h0002_0000, 1'b1, 32'h0001_2345);
    c = kf(MODE_LINEAR, 32'h1000, 32'h1000, 32'h0000_aaaa, 32'h0000_5555, 32'h0, 32'h0);
    add_probe(1'b1, c, 32'h0000_1000, 1'b1, 32'h0000_5555);
    add_probe(1'b0, c, 32'h0000_0fff, 1'b1, 32'h0000_aaaa);
    // end keyframe before start
    c = kf(MODE_CURVE, 32'h5000, 32'hffff_b000, 32'hffff_ffff, 32'h7fff_0000, 32'h1, 32'h2);
    add_probe(1'b1, c, 32'h0000_5000, 1'b1, 32'h7fff_0000);
    add_probe(1'b0, c, 32'h0000_0000, 1'b1, 32'hffff_ffff);
    add_probe(1'b0, c, VAL_MAX, 1'b1, 32'h7fff_0000);
    // widest span: one step past start truncates t to zero
    c = kf(MODE_LINEAR, VAL_MIN, VAL_MAX, 32'h0000_0100, VAL_MAX, 32'h0, 32'h0);
    add_probe(1'b1, c, VAL_MIN + 1, 1'b1, 32'h0000_0100);
    add_probe(1'b0, c, VAL_MAX - 1, 1'b0, '0);
    add_probe(1'b0, c, 32'h0000_0000, 1'b0, '0);
    c = kf(MODE_CURVE, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0003_0000,
           32'hfffd_0000);
    add_probe(1'b1, c, 32'h0000_8000, 1'b0, '0);
    add_probe(1'b0, c, 32'h0000_4000, 1'b0, '0);
    c.mode = MODE_CURVE_HI;
    add_probe(1'b1, c, 32'h0000_8000, 1'b0, '0);
    add_probe(1'b0, c, 32'h0000_c000, 1'b0, '0);
    c = kf(MODE_CURVE, 32'hffff_0000, 32'h0001_0000, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN);
    add_probe(1'b1, c, 32'h0000_0000, 1'b0, '0);
    add_probe(1'b0, c, 32'hffff_ffff, 1'b0, '0);
    c = kf(MODE_LINEAR, 32'h0, 32'h0000_0003, VAL_MAX, VAL_MIN, 32'h0, 32'h0);
    add_probe(1'b1, c, 32'h0000_0001, 1'b0, '0);

    foreach (probe_rows[i]) begin
      if (probe_rows[i].load) begin
        settle();
        apply_keyframes(probe_rows[i].cfg);
      end
      send_query(probe_rows[i].query, probe_rows[i].known, probe_rows[i].value);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0:       c = kf(MODE_CURVE, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN);
        1:       c = kf(MODE_LINEAR, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, '0, '0);
        default: c = pick_keyframes();
      endcase
      apply_keyframes(c);
      n = $urandom_range(40, 140);
      repeat (n) send_query(pick_query(c), 1'b0, '0);
      sent += n;
      phase++;
    end

    settle();
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("keyframe_channel_interpolator regression: pass");
    end else begin
      $display("keyframe_channel_interpolator regression: fail");
    end
    $finish;
  end

endmodule
